// File: src/tcwa_pkg.sv
// ============================================================================
// tcwa_pkg
// Shared types and constants of the two-channel converter window averager.
// ============================================================================
`default_nettype none

package tcwa_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int TIME_W       = 32;
    localparam int INTERVAL_W   = 16;
    localparam int BATTERY_W    = 9;
    localparam int LIGHT_W      = 12;
    localparam int PROD_W       = 24;
    localparam int SCALE_SHIFT  = 12;
    localparam int NUM_CH       = 2;
    localparam int CH_BATTERY   = 0;
    localparam int CH_LIGHT     = 1;
    localparam int MID_DEPTH    = 4;
    localparam int OUT_DEPTH    = 8;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [BATTERY_W-1:0]  BATTERY_OFFSET = 9'd23;

    localparam logic [SAMPLE_W-1:0] CH_GAIN [NUM_CH] = '{12'd330, 12'd3300};

    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_POLL    = 1'b1
    } t_op;

    typedef struct packed {
        logic [SAMPLE_W-1:0] battery;
        logic [SAMPLE_W-1:0] light;
    } t_sample_pair;

    typedef struct packed {
        logic [BATTERY_W-1:0] battery_scaled;
        logic [LIGHT_W-1:0]   light_millivolts;
    } t_result;

endpackage

`default_nettype wire

// File: src/tcwa_fifo.sv
// ============================================================================
// tcwa_fifo
// Small synchronous queue with full and empty flags; depth is a power of two.
// ============================================================================
`default_nettype none

module tcwa_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;
    logic             wr_en;
    logic             rd_en;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]) && (r_wr_ptr[AW] != r_rd_ptr[AW]);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/tcwa_front.sv
// ============================================================================
// tcwa_front
// Takes input words, tracks the pending conversion and the poll rate limit,
// and queues the samples of every poll that passes.
// ============================================================================
`default_nettype none

module tcwa_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [tcwa_pkg::INTERVAL_W-1:0]   i_cfg_wr_data,
    input  wire logic                              i_push,
    input  wire logic                              i_q_full,
    input  wire logic                              i_operation,
    input  wire logic [tcwa_pkg::TIME_W-1:0]       i_now_ms,
    input  wire logic [tcwa_pkg::SAMPLE_W-1:0]     i_battery_raw,
    input  wire logic [tcwa_pkg::SAMPLE_W-1:0]     i_light_raw,
    output logic                                   o_q_push,
    output tcwa_pkg::t_sample_pair                 o_q_data
);

    import tcwa_pkg::*;

    logic [INTERVAL_W-1:0] r_interval;
    logic [TIME_W-1:0]     r_last_time;
    logic                  r_pending;
    logic [TIME_W-1:0]     n_last_time;
    logic                  n_pending;
    logic [TIME_W-1:0]     elapsed;
    logic                  take;
    logic                  poll_ok;

    always_comb begin
        // Wrapping difference: the tick counter rolls over modulo 2^32.
        elapsed = i_now_ms - r_last_time;
        take    = i_push && !i_q_full;
        poll_ok = take && (t_op'(i_operation) == OP_POLL) && r_pending
                  && (elapsed > TIME_W'(r_interval));

        n_pending   = r_pending;
        n_last_time = r_last_time;
        if (take && (t_op'(i_operation) == OP_CONVERT)) begin
            n_pending = 1'b1;
        end else if (poll_ok) begin
            n_pending   = 1'b0;
            n_last_time = i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RESET;
            r_last_time <= '0;
            r_pending   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
            r_last_time <= n_last_time;
            r_pending   <= n_pending;
        end
    end

    assign o_q_push         = poll_ok;
    assign o_q_data.battery = i_battery_raw;
    assign o_q_data.light   = i_light_raw;

endmodule

`default_nettype wire

// File: src/tcwa_back.sv
// ============================================================================
// tcwa_back
// Updates the sample windows and running sums, then averages and scales
// both channels in a four-stage pipeline. A credit count guarantees room in
// the result queue for every word in flight.
// ============================================================================
`default_nettype none

module tcwa_back #(
    parameter int WINDOW_LEN = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_mid_empty,
    input  tcwa_pkg::t_sample_pair      i_mid_data,
    output logic                        o_mid_pop,
    input  wire logic                   i_res_taken,
    output logic                        o_res_push,
    output tcwa_pkg::t_result           o_res
);

    import tcwa_pkg::*;

    localparam int SUM_W    = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);
    localparam int SLOT_W   = $clog2(WINDOW_LEN);
    localparam int PQ_W     = 2 * SUM_W;
    localparam int RECIP    = (2 ** SUM_W) / WINDOW_LEN;
    localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

    // Window state
    logic [SAMPLE_W-1:0] r_win [NUM_CH][WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum [NUM_CH];
    logic [SLOT_W-1:0]   r_slot;
    logic                r_full;
    logic [CREDIT_W-1:0] r_credit;

    // Pipeline stages
    logic                r_s1_valid;
    logic                r_s1_use_avg;
    logic [SAMPLE_W-1:0] r_s1_samp [NUM_CH];
    logic                r_s2_valid;
    logic                r_s2_use_avg;
    logic [SAMPLE_W-1:0] r_s2_samp [NUM_CH];
    logic [SUM_W-1:0]    r_s2_sum  [NUM_CH];
    logic [PQ_W-1:0]     r_s2_prod [NUM_CH];
    logic                r_s3_valid;
    logic [SAMPLE_W-1:0] r_s3_avg  [NUM_CH];
    logic                r_s4_valid;
    logic [PROD_W-1:0]   r_s4_prod [NUM_CH];

    logic                pop;
    logic                last_slot;
    logic                n_full;
    logic [SAMPLE_W-1:0] samp_in [NUM_CH];
    logic [SUM_W-1:0]    n_sum   [NUM_CH];
    logic [SAMPLE_W-1:0] quot    [NUM_CH];
    logic [SUM_W-1:0]    rem     [NUM_CH];
    logic [SAMPLE_W-1:0] n_avg   [NUM_CH];
    logic [CREDIT_W-1:0] n_credit;

    assign pop       = !i_mid_empty && (r_credit < CREDIT_W'(OUT_DEPTH));
    assign o_mid_pop = pop;
    assign last_slot = (r_slot == SLOT_W'(WINDOW_LEN - 1));
    assign n_full    = r_full || last_slot;

    always_comb begin
        samp_in[CH_BATTERY] = i_mid_data.battery;
        samp_in[CH_LIGHT]   = i_mid_data.light;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sum[ch] = r_sum[ch] - SUM_W'(r_win[ch][r_slot]) + SUM_W'(samp_in[ch]);
        end
    end

    // Division by the window length: multiply by a truncated reciprocal,
    // which can come out one low, then fix it with one compare.
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            quot[ch] = r_s2_prod[ch][SUM_W +: SAMPLE_W];
            rem[ch]  = r_s2_sum[ch] - SUM_W'(quot[ch]) * SUM_W'(WINDOW_LEN);
            if (!r_s2_use_avg) begin
                n_avg[ch] = r_s2_samp[ch];
            end else if (rem[ch] >= SUM_W'(WINDOW_LEN)) begin
                n_avg[ch] = quot[ch] + 1'b1;
            end else begin
                n_avg[ch] = quot[ch];
            end
        end
    end

    always_comb begin
        n_credit = r_credit;
        if (pop && !i_res_taken) begin
            n_credit = r_credit + 1'b1;
        end else if (!pop && i_res_taken) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_sum[ch] <= '0;
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    r_win[ch][i] <= '0;
                end
            end
            r_slot     <= '0;
            r_full     <= 1'b0;
            r_credit   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (pop) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r_win[ch][r_slot] <= samp_in[ch];
                    r_sum[ch]         <= n_sum[ch];
                end
                r_slot <= last_slot ? '0 : r_slot + 1'b1;
                r_full <= n_full;
            end
            r_credit   <= n_credit;
            r_s1_valid <= pop;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Payload stages. Stage two reads the running sums the cycle after they
    // were updated, before any later word can change them.
    always_ff @(posedge i_clk) begin
        r_s1_use_avg <= n_full;
        r_s2_use_avg <= r_s1_use_avg;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            r_s1_samp[ch] <= samp_in[ch];
            r_s2_samp[ch] <= r_s1_samp[ch];
            r_s2_sum[ch]  <= r_sum[ch];
            r_s2_prod[ch] <= PQ_W'(r_sum[ch]) * PQ_W'(RECIP);
            r_s3_avg[ch]  <= n_avg[ch];
            r_s4_prod[ch] <= PROD_W'(r_s3_avg[ch]) * PROD_W'(CH_GAIN[ch]);
        end
    end

    assign o_res_push = r_s4_valid;
    assign o_res.battery_scaled =
        r_s4_prod[CH_BATTERY][SCALE_SHIFT +: BATTERY_W] + BATTERY_OFFSET;
    assign o_res.light_millivolts = r_s4_prod[CH_LIGHT][SCALE_SHIFT +: LIGHT_W];

endmodule

`default_nettype wire

// File: src/two_channel_adc_window_averager.sv
// ============================================================================
// two_channel_adc_window_averager
// Rate-limited moving average of a battery and a light sensor channel.
// ============================================================================
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+------------------
//  input    | i_operation, i_now_ms, i_battery_raw,        | push / full
//           | i_light_raw                                  |
//  result   | o_battery_scaled, o_light_millivolts         | empty / pop
//  config   | i_cfg_wr_data (interval_ms)                  | i_cfg_wr_en
//
//  One input word is taken per cycle while full is low. A passing poll is
//  written to the poll queue, popped into the averaging and scaling pipeline
//  when the result queue has room, and the last pipeline stage writes the
//  result queue, whose head drives the result ports.
//  full rises only when the four-entry poll queue is full, which happens when
//  results are not popped and eight words fill the pipeline and result queue.
//  Synchronous reset clears the windows, sums and queues.
// ============================================================================
`default_nettype none

module two_channel_adc_window_averager #(
    parameter int WINDOW_LEN = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [tcwa_pkg::INTERVAL_W-1:0] i_cfg_wr_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            i_operation,
    input  wire logic [tcwa_pkg::TIME_W-1:0]     i_now_ms,
    input  wire logic [tcwa_pkg::SAMPLE_W-1:0]   i_battery_raw,
    input  wire logic [tcwa_pkg::SAMPLE_W-1:0]   i_light_raw,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [tcwa_pkg::BATTERY_W-1:0]       o_battery_scaled,
    output logic [tcwa_pkg::LIGHT_W-1:0]         o_light_millivolts
);

    import tcwa_pkg::*;

    logic         q_push;
    t_sample_pair q_in;
    t_sample_pair q_out;
    logic         q_full;
    logic         q_empty;
    logic         q_pop;
    logic         res_push;
    t_result      res_in;
    t_result      res_out;
    logic         res_full;
    logic         res_taken;

    assign full      = q_full;
    assign res_taken = pop && !empty;

    tcwa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_push        (push),
        .i_q_full      (q_full),
        .i_operation   (i_operation),
        .i_now_ms      (i_now_ms),
        .i_battery_raw (i_battery_raw),
        .i_light_raw   (i_light_raw),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    tcwa_fifo #(
        .WIDTH ($bits(t_sample_pair)),
        .DEPTH (MID_DEPTH)
    ) u_poll_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    tcwa_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (q_empty),
        .i_mid_data  (q_out),
        .o_mid_pop   (q_pop),
        .i_res_taken (res_taken),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // The back end only issues a word when the result queue has room for it,
    // so res_full never blocks a push.
    tcwa_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_battery_scaled   = res_out.battery_scaled;
    assign o_light_millivolts = res_full ? res_out.light_millivolts : res_out.light_millivolts;

endmodule

`default_nettype wire

// File: src/tcwa_checker.sv
// ============================================================================
// tcwa_checker
// Port-level checks of the window averager, bound to the top level.
// ============================================================================
`default_nettype none

module tcwa_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            full,
    input wire logic                            empty,
    input wire logic                            pop,
    input wire logic [tcwa_pkg::BATTERY_W-1:0]  o_battery_scaled,
    input wire logic [tcwa_pkg::LIGHT_W-1:0]    o_light_millivolts
);

    // Reset leaves both queues empty.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // The battery word always carries the offset and stays in range.
    a_battery_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_battery_scaled >= 9'd23 && o_battery_scaled <= 9'd352))
        else $error("battery word out of range");

    a_light_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_light_millivolts <= 12'd3299))
        else $error("light word out of range");

    // A waiting result word is held until it is popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_battery_scaled)
                              && $stable(o_light_millivolts)))
        else $error("result word changed while waiting");

endmodule

bind two_channel_adc_window_averager tcwa_checker u_tcwa_checker (.*);

`default_nettype wire
